[hw/rtl/sphpbi_pkg.sv]
// shared constants and types for the particle boundary integrate unit
`default_nettype none
package sphpbi_pkg;
    localparam int WALL_THICKNESS_DEF = 4194;
    localparam int BARRIER_LIM = 4194;
    localparam int DATA_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // reciprocal of 3 scaled by 2^21, exact floor for 20-bit operands
    localparam logic [19:0] THIRD_RECIP = 20'd699051;
    localparam logic [19:0] BARRIER_HALF_RST = 20'd16777;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_HALF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_K = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_D = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BAR_EN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BAR_K = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BAR_D = 3'd7;

    typedef struct packed {
        logic [19:0] time_step;
        logic [19:0] wall_half_length;
        logic [19:0] barrier_half;
        logic signed [31:0] gravity_y;
        logic [15:0] wall_stiffness;
        logic [11:0] wall_damping;
        logic barrier_enable;
        logic [15:0] barrier_stiffness;
        logic [11:0] barrier_damping;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] fluid_acc_x;
        logic signed [31:0] fluid_acc_y;
        logic signed [31:0] fluid_acc_z;
    } particle_t;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_pos_z;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage
`default_nettype wire

[hw/rtl/sphpbi_if.sv]
// valid/ready channel interfaces
`default_nettype none
interface sphpbi_in_if
    import sphpbi_pkg::*;
;
    logic valid;
    logic ready;
    particle_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sphpbi_out_if
    import sphpbi_pkg::*;
;
    logic valid;
    logic ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sphpbi_cfg_if
    import sphpbi_pkg::*;
;
    logic valid;
    logic ready;
    cfg_wr_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/sphpbi_cfg_regs.sv]
// configuration register file
`default_nettype none
module sphpbi_cfg_regs
    import sphpbi_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    sphpbi_cfg_if.sink cfg,
    output cfg_t cfg_q
);
    cfg_t cfg_reg;
    logic [40:0] third_prod;

    assign cfg.ready = 1'b1;
    assign cfg_q = cfg_reg;

    // barrier half size floor(L/3) by reciprocal multiply
    assign third_prod = 41'(cfg.data.data[19:0]) * 41'(THIRD_RECIP);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.time_step <= 20'd3146;
            cfg_reg.wall_half_length <= 20'd50332;
            cfg_reg.barrier_half <= BARRIER_HALF_RST;
            cfg_reg.gravity_y <= -32'sd10276045;
            cfg_reg.wall_stiffness <= 16'd10000;
            cfg_reg.wall_damping <= 12'd256;
            cfg_reg.barrier_enable <= 1'b0;
            cfg_reg.barrier_stiffness <= 16'd40000;
            cfg_reg.barrier_damping <= 12'd400;
        end
        else if (cfg.valid)
        begin
            case (cfg.data.index)
                REG_TIME_STEP: cfg_reg.time_step <= cfg.data.data[19:0];
                REG_WALL_HALF:
                begin
                    cfg_reg.wall_half_length <= cfg.data.data[19:0];
                    cfg_reg.barrier_half <= third_prod[40:21];
                end
                REG_GRAVITY_Y: cfg_reg.gravity_y <= cfg.data.data[31:0];
                REG_WALL_K: cfg_reg.wall_stiffness <= cfg.data.data[15:0];
                REG_WALL_D: cfg_reg.wall_damping <= cfg.data.data[11:0];
                REG_BAR_EN: cfg_reg.barrier_enable <= cfg.data.data[0];
                REG_BAR_K: cfg_reg.barrier_stiffness <= cfg.data.data[15:0];
                REG_BAR_D: cfg_reg.barrier_damping <= cfg.data.data[11:0];
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

[hw/rtl/sphpbi_force.sv]
// per-axis penalty force from one wall: k*pen - d*vn, registered
`default_nettype none
module sphpbi_force
    import sphpbi_pkg::*;
(
    input wire logic clk,
    input wire logic en,
    input wire logic act,
    input wire logic signed [33:0] pen,
    input wire logic [15:0] k,
    input wire logic [11:0] d,
    input wire logic signed [32:0] vn,
    output logic signed [52:0] force_q
);
    logic signed [52:0] spring;
    logic signed [52:0] damp;
    logic signed [52:0] force_next;
    logic signed [52:0] force_reg;

    // spring and damping products
    always_comb
    begin
        spring = 53'(pen) * 53'($signed({1'b0, k}));
        damp = 53'($signed({1'b0, d})) * 53'(vn);
        force_next = act ? (spring - damp) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            force_reg <= force_next;
    end

    assign force_q = force_reg;
endmodule
`default_nettype wire

[hw/rtl/sph_particle_boundary_integrate_unit.sv]
// top level: boundary forces and kinematic step, five-stage pipeline
// the result is valid once the input transaction has passed five register stages
// throughput: one particle per cycle; the whole pipeline holds while a result waits on ready
// stages: wall tests, force products, force sum, dv product, displacement product
// reset clears all valid bits and loads the register defaults
`default_nettype none
module sph_particle_boundary_integrate_unit
    import sphpbi_pkg::*;
#(
    parameter int WALL_THICKNESS = WALL_THICKNESS_DEF
)
(
    input wire logic clk,
    input wire logic rst_n,
    sphpbi_in_if.sink in_ch,
    sphpbi_out_if.source out_ch,
    sphpbi_cfg_if.sink cfg
);
    localparam int NS = 5;

    cfg_t c;
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic adv;

    sphpbi_cfg_regs u_cfg (.clk(clk), .rst_n(rst_n), .cfg(cfg), .cfg_q(c));

    // pipeline advances when output slot is free
    assign adv = !vld_reg[NS-1] || out_ch.ready;
    assign in_ch.ready = adv;

    always_comb
    begin
        vld_next = {vld_reg[NS-2:0], in_ch.valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    // stage 1: penetrations and region tests
    logic signed [33:0] pen_next [10];
    logic [9:0] act_next;
    logic signed [33:0] pen_reg [10];
    logic [9:0] act_reg;
    logic signed [31:0] p1_reg [3];
    logic signed [31:0] v1_reg [3];
    logic signed [33:0] a1_reg [3];

    always_comb
    begin
        logic signed [33:0] px, py, pz, ll, b, th, lim;
        logic in_x, in_z, below, in_zl, en;
        px = 34'(in_ch.data.pos_x);
        py = 34'(in_ch.data.pos_y);
        pz = 34'(in_ch.data.pos_z);
        ll = $signed({14'd0, c.wall_half_length});
        b = $signed({14'd0, c.barrier_half});
        th = 34'(WALL_THICKNESS);
        lim = 34'(BARRIER_LIM);
        en = c.barrier_enable;
        pen_next[0] = th - (px + ll);
        pen_next[1] = th - (ll - px);
        pen_next[2] = th - py;
        pen_next[3] = th - (pz + ll);
        pen_next[4] = th - (ll - pz);
        for (int i = 0; i < 5; i++)
            act_next[i] = pen_next[i] > 0;
        in_x = px < b && px > -b;
        in_z = pz < b && pz > -b;
        below = py < b - lim;
        in_zl = pz < b - lim && pz > -b + lim;
        pen_next[5] = b - py;
        pen_next[6] = b - px;
        pen_next[7] = px + b;
        pen_next[8] = b - pz;
        pen_next[9] = pz + b;
        act_next[5] = en && in_x && in_z;
        act_next[6] = en && in_zl && below && px > 0;
        act_next[7] = en && in_zl && below && px < 0;
        act_next[8] = en && in_x && below && pz > 0;
        act_next[9] = en && in_x && below && pz < 0;
        for (int i = 5; i < 10; i++)
            act_next[i] = act_next[i] && pen_next[i] > 0 && pen_next[i] < lim;
    end

    // gravity added at full width
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pen_reg <= pen_next;
            act_reg <= act_next;
            p1_reg <= '{in_ch.data.pos_x, in_ch.data.pos_y, in_ch.data.pos_z};
            v1_reg <= '{in_ch.data.vel_x, in_ch.data.vel_y, in_ch.data.vel_z};
            a1_reg <= '{34'(in_ch.data.fluid_acc_x),
                        34'(in_ch.data.fluid_acc_y) + 34'(c.gravity_y),
                        34'(in_ch.data.fluid_acc_z)};
        end
    end

    // stage 2: force products (normal velocity negated on faces that push toward the negative axis)
    localparam int AX [10] = '{0, 0, 1, 2, 2, 1, 0, 0, 2, 2};
    logic signed [52:0] f_q [10];
    logic signed [31:0] p2_reg [3];
    logic signed [31:0] v2_reg [3];
    logic signed [33:0] a2_reg [3];

    for (genvar g = 0; g < 10; g++)
    begin : g_force
        logic signed [32:0] vn;
        logic neg;
        assign neg = (g == 1) || (g == 4) || (g == 7) || (g == 9);
        assign vn = neg ? -33'(v1_reg[AX[g]]) : 33'(v1_reg[AX[g]]);
        sphpbi_force u_f (
            .clk(clk), .en(adv), .act(act_reg[g]), .pen(pen_reg[g]),
            .k(g < 5 ? c.wall_stiffness : c.barrier_stiffness),
            .d(g < 5 ? c.wall_damping : c.barrier_damping),
            .vn(vn), .force_q(f_q[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_reg <= p1_reg;
            v2_reg <= v1_reg;
            a2_reg <= a1_reg;
        end
    end

    // stage 3: sum forces, saturate acceleration
    logic signed [31:0] acc_next [3];
    logic signed [31:0] acc_reg [3];
    logic signed [31:0] p3_reg [3];
    logic signed [31:0] v3_reg [3];

    always_comb
    begin
        logic signed [63:0] sx, sy, sz;
        sx = 64'(a2_reg[0]) + 64'(f_q[0]) - 64'(f_q[1]) + 64'(f_q[6]) - 64'(f_q[7]);
        sy = 64'(a2_reg[1]) + 64'(f_q[2]) + 64'(f_q[5]);
        sz = 64'(a2_reg[2]) + 64'(f_q[3]) - 64'(f_q[4]) + 64'(f_q[8]) - 64'(f_q[9]);
        acc_next[0] = sat32(sx);
        acc_next[1] = sat32(sy);
        acc_next[2] = sat32(sz);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            acc_reg <= acc_next;
            p3_reg <= p2_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage 4: dv = round(a*dt / 2^20), w = 2v + dv
    logic signed [33:0] dv_next [3];
    logic signed [34:0] w_next [3];
    logic signed [33:0] dv_reg [3];
    logic signed [34:0] w_reg [3];
    logic signed [31:0] p4_reg [3];
    logic signed [31:0] v4_reg [3];

    always_comb
    begin
        logic signed [63:0] dv_full;
        for (int i = 0; i < 3; i++)
        begin
            dv_full = (64'(acc_reg[i]) * $signed({44'd0, c.time_step})
                       + 64'sd524288) >>> 20;
            dv_next[i] = 34'(dv_full);
            w_next[i] = 35'(2 * 64'(v3_reg[i])) + 35'(dv_full);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_reg <= dv_next;
            w_reg <= w_next;
            p4_reg <= p3_reg;
            v4_reg <= v3_reg;
        end
    end

    // stage 5: disp = round(w*dt / 2^21), saturate outputs
    result_t res_next;
    result_t res_reg;

    always_comb
    begin
        logic signed [63:0] disp [3];
        for (int i = 0; i < 3; i++)
            disp[i] = (64'(w_reg[i]) * $signed({44'd0, c.time_step})
                       + 64'sd1048576) >>> 21;
        res_next.new_pos_x = sat32(64'(p4_reg[0]) + disp[0]);
        res_next.new_pos_y = sat32(64'(p4_reg[1]) + disp[1]);
        res_next.new_pos_z = sat32(64'(p4_reg[2]) + disp[2]);
        res_next.new_vel_x = sat32(64'(v4_reg[0]) + 64'(dv_reg[0]));
        res_next.new_vel_y = sat32(64'(v4_reg[1]) + 64'(dv_reg[1]));
        res_next.new_vel_z = sat32(64'(v4_reg[2]) + 64'(dv_reg[2]));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            res_reg <= res_next;
    end

    assign out_ch.valid = vld_reg[NS-1];
    assign out_ch.data = res_reg;
endmodule
`default_nettype wire

[verif/tb_sph_particle_boundary_integrate_unit.sv]
// testbench for the particle boundary integrate unit: predictor, scoreboard, stimulus
`timescale 1ns / 1ps
`default_nettype none

class pbi_scoreboard;
    sphpbi_pkg::result_t expected_q[$];
    int unsigned err_count;

    // configuration copy
    longint unsigned step_dt;
    longint half_len;
    longint grav_y;
    longint wall_k;
    longint wall_d;
    bit bar_en;
    longint bar_k;
    longint bar_d;

    function new();
        err_count = 0;
        step_dt = 3146;
        half_len = 50332;
        grav_y = -10276045;
        wall_k = 10000;
        wall_d = 256;
        bar_en = 0;
        bar_k = 40000;
        bar_d = 400;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            sphpbi_pkg::REG_TIME_STEP: step_dt = val[19:0];
            sphpbi_pkg::REG_WALL_HALF: half_len = val[19:0];
            sphpbi_pkg::REG_GRAVITY_Y: grav_y = longint'($signed(val));
            sphpbi_pkg::REG_WALL_K: wall_k = val[15:0];
            sphpbi_pkg::REG_WALL_D: wall_d = val[11:0];
            sphpbi_pkg::REG_BAR_EN: bar_en = val[0];
            sphpbi_pkg::REG_BAR_K: bar_k = val[15:0];
            sphpbi_pkg::REG_BAR_D: bar_d = val[11:0];
            default: ;
        endcase
    endfunction

    function longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // divide by 2^s, nearest with ties upward
    function longint round_shift(longint x, int s);
        longint y;
        y = x + (longint'(1) <<< (s - 1));
        return y >>> s;
    endfunction

    function sphpbi_pkg::result_t integrate(sphpbi_pkg::particle_t it);
        longint p[3], v[3], a[3];
        longint pen, b, acc, dv, w, disp;
        longint lim;
        bit in_x, in_z, below, in_zl;
        logic signed [31:0] np[3], nv[3];
        sphpbi_pkg::result_t r;
        p[0] = it.pos_x; p[1] = it.pos_y; p[2] = it.pos_z;
        v[0] = it.vel_x; v[1] = it.vel_y; v[2] = it.vel_z;
        a[0] = it.fluid_acc_x; a[1] = it.fluid_acc_y; a[2] = it.fluid_acc_z;
        lim = sphpbi_pkg::BARRIER_LIM;
        a[1] += grav_y;
        // container walls, no top
        pen = sphpbi_pkg::WALL_THICKNESS_DEF - (p[0] + half_len);
        if (pen > 0) a[0] += wall_k * pen - wall_d * v[0];
        pen = sphpbi_pkg::WALL_THICKNESS_DEF - (half_len - p[0]);
        if (pen > 0) a[0] -= wall_k * pen + wall_d * v[0];
        pen = sphpbi_pkg::WALL_THICKNESS_DEF - p[1];
        if (pen > 0) a[1] += wall_k * pen - wall_d * v[1];
        pen = sphpbi_pkg::WALL_THICKNESS_DEF - (p[2] + half_len);
        if (pen > 0) a[2] += wall_k * pen - wall_d * v[2];
        pen = sphpbi_pkg::WALL_THICKNESS_DEF - (half_len - p[2]);
        if (pen > 0) a[2] -= wall_k * pen + wall_d * v[2];
        // central barrier box
        if (bar_en) begin
            b = half_len / 3;
            in_x = p[0] < b && p[0] > -b;
            in_z = p[2] < b && p[2] > -b;
            below = p[1] < b - lim;
            in_zl = p[2] < b - lim && p[2] > -b + lim;
            if (in_x && in_z) begin
                pen = b - p[1];
                if (pen > 0 && pen < lim) a[1] += bar_k * pen - bar_d * v[1];
            end
            if (in_zl && below && p[0] > 0) begin
                pen = b - p[0];
                if (pen > 0 && pen < lim) a[0] += bar_k * pen - bar_d * v[0];
            end
            if (in_zl && below && p[0] < 0) begin
                pen = p[0] + b;
                if (pen > 0 && pen < lim) a[0] -= bar_k * pen + bar_d * v[0];
            end
            if (in_x && below && p[2] > 0) begin
                pen = b - p[2];
                if (pen > 0 && pen < lim) a[2] += bar_k * pen - bar_d * v[2];
            end
            if (in_x && below && p[2] < 0) begin
                pen = p[2] + b;
                if (pen > 0 && pen < lim) a[2] -= bar_k * pen + bar_d * v[2];
            end
        end
        // kinematic step per axis
        for (int i = 0; i < 3; i++) begin
            acc = clamp32(a[i]);
            dv = round_shift(acc * longint'(step_dt), 20);
            w = 2 * v[i] + dv;
            disp = round_shift(w * longint'(step_dt), 21);
            np[i] = clamp32(p[i] + disp);
            nv[i] = clamp32(v[i] + dv);
        end
        r.new_pos_x = np[0]; r.new_pos_y = np[1]; r.new_pos_z = np[2];
        r.new_vel_x = nv[0]; r.new_vel_y = nv[1]; r.new_vel_z = nv[2];
        return r;
    endfunction

    function void note_particle(sphpbi_pkg::particle_t it);
        expected_q.insert(expected_q.size(), integrate(it));
    endfunction

    function void check_field(string nm, logic [31:0] e, logic [31:0] g);
        if (e !== g) begin
            $display("%0t: mismatch %s expected %h actual %h", $time, nm, e, g);
            err_count++;
        end
    endfunction

    function void check_result(sphpbi_pkg::result_t got);
        sphpbi_pkg::result_t e;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result expected none actual %h", $time, got);
            err_count++;
            return;
        end
        e = expected_q.pop_front();
        check_field("new_pos_x", e.new_pos_x, got.new_pos_x);
        check_field("new_pos_y", e.new_pos_y, got.new_pos_y);
        check_field("new_pos_z", e.new_pos_z, got.new_pos_z);
        check_field("new_vel_x", e.new_vel_x, got.new_vel_x);
        check_field("new_vel_y", e.new_vel_y, got.new_vel_y);
        check_field("new_vel_z", e.new_vel_z, got.new_vel_z);
    endfunction
endclass

module tb_sph_particle_boundary_integrate_unit;
    import sphpbi_pkg::*;

    localparam longint CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    int send_idle_pct;
    int recv_idle_pct;
    longint cycle_count;

    sphpbi_in_if in_ch();
    sphpbi_out_if out_ch();
    sphpbi_cfg_if cfg();

    pbi_scoreboard sb;

    sph_particle_boundary_integrate_unit u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source),
        .cfg(cfg.sink)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // timeout watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // result sink with random stall
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.data);
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // input transaction monitor
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            sb.note_particle(in_ch.data);
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg.valid <= 1'b1;
        cfg.data.index <= idx;
        cfg.data.data <= val;
        do @(posedge clk); while (!cfg.ready);
        sb.write_reg(idx, val);
        cfg.valid <= 1'b0;
    endtask

    task automatic send_particle(particle_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(3))
            0: return w;
            1: return $signed(w) >>> $urandom_range(31);
            default: return $signed(w) >>> (10 + $urandom_range(12));
        endcase
    endfunction

    // position near walls and barrier faces for the current geometry, sometimes uniform or random
    function automatic logic [31:0] near_coord(bit vert);
        longint l, b, c;
        l = sb.half_len;
        b = l / 3;
        case ($urandom_range(vert ? 2 : 5))
            0: c = vert ? $urandom_range(8400) - 4200 : l - $urandom_range(8400);
            1: c = b + 4200 - $urandom_range(8400);
            2: c = $urandom_range(2 * l + 1) - l;
            3: c = -l + $urandom_range(8400);
            4: c = -b + 4200 - $urandom_range(8400);
            default: c = longint'($signed(rand_word()));
        endcase
        return c;
    endfunction

    function automatic particle_t rand_particle();
        particle_t it;
        if ($urandom_range(9) < 8)
        begin
            it.pos_x = near_coord(0);
            it.pos_y = ($urandom_range(1)) ? near_coord(1) : sb.half_len / 3 + 50 - $urandom_range(4300);
            it.pos_z = near_coord(0);
        end
        else
        begin
            it.pos_x = rand_word();
            it.pos_y = rand_word();
            it.pos_z = rand_word();
        end
        it.vel_x = rand_word();
        it.vel_y = rand_word();
        it.vel_z = rand_word();
        it.fluid_acc_x = rand_word();
        it.fluid_acc_y = rand_word();
        it.fluid_acc_z = rand_word();
        return it;
    endfunction

    task automatic directed_part();
        particle_t it;
        logic [31:0] ext[4];
        ext[0] = 32'h7fffffff; ext[1] = 32'h80000000; ext[2] = 0; ext[3] = 32'hffffffff;
        for (int i = 0; i < 4; i++)
        begin
            it = {9{ext[i]}};
            send_particle(it);
        end
        // each wall, the floor and the barrier faces
        it = '0;
        it.vel_x = 32'sd300000; it.vel_y = -32'sd200000; it.vel_z = 32'sd100000;
        it.pos_x = -sb.half_len; it.pos_y = 32'sd1000000; send_particle(it);
        it.pos_x = sb.half_len; send_particle(it);
        it.pos_x = 0; it.pos_y = 100; send_particle(it);
        it.pos_y = 32'sd1000000; it.pos_z = -sb.half_len; send_particle(it);
        it.pos_z = sb.half_len; send_particle(it);
        it.pos_x = 0; it.pos_z = 0; it.pos_y = sb.half_len / 3 - 2000; send_particle(it);
        it.pos_y = 0; it.pos_x = sb.half_len / 3 - 2000; send_particle(it);
        it.pos_x = -(sb.half_len / 3) + 2000; send_particle(it);
        it.pos_x = 0; it.pos_z = sb.half_len / 3 - 2000; send_particle(it);
        it.pos_z = -(sb.half_len / 3) + 2000; send_particle(it);
        for (int i = 0; i < 6; i++)
            send_particle(rand_particle());
        drain();
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            send_particle(rand_particle());
        drain();
    endtask

    task automatic random_config();
        write_reg(REG_TIME_STEP, $urandom_range(1, 20000));
        write_reg(REG_WALL_HALF, $urandom_range(20000, 300000));
        write_reg(REG_GRAVITY_Y, rand_word());
        write_reg(REG_WALL_K, $urandom_range(65535));
        write_reg(REG_WALL_D, $urandom_range(4095));
        write_reg(REG_BAR_EN, $urandom_range(1));
        write_reg(REG_BAR_K, $urandom_range(65535));
        write_reg(REG_BAR_D, $urandom_range(4095));
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        out_ch.ready = 1'b0;
        send_idle_pct = 21;
        recv_idle_pct = 55;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_part();
        random_phase(250);

        // barrier on at defaults
        write_reg(REG_BAR_EN, 1);
        directed_part();
        random_phase(250);

        // upper extremes
        write_reg(REG_TIME_STEP, 20'hfffff);
        write_reg(REG_WALL_HALF, 20'hfffff);
        write_reg(REG_GRAVITY_Y, 32'h7fffffff);
        write_reg(REG_WALL_K, 16'hffff);
        write_reg(REG_WALL_D, 12'hfff);
        write_reg(REG_BAR_K, 16'hffff);
        write_reg(REG_BAR_D, 12'hfff);
        directed_part();
        random_phase(150);

        send_idle_pct = 55;
        recv_idle_pct = 21;
        // lower extremes
        write_reg(REG_TIME_STEP, 1);
        write_reg(REG_WALL_HALF, 0);
        write_reg(REG_GRAVITY_Y, 32'h80000000);
        write_reg(REG_WALL_K, 0);
        write_reg(REG_WALL_D, 0);
        write_reg(REG_BAR_EN, 0);
        write_reg(REG_BAR_K, 0);
        write_reg(REG_BAR_D, 0);
        random_phase(150);
        write_reg(REG_TIME_STEP, 0);
        random_phase(50);

        for (int ph = 0; ph < 4; ph++)
        begin
            if (ph == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_config();
            random_phase(280);
        end

        if (sb.err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

`default_nettype wire
